// File: rtl/core/dfu_pkg.sv
`default_nettype none

package dfu_pkg;

    // DFU protocol states, in specification order
    typedef enum logic [3:0] {
        ST_APP_IDLE   = 4'd0,
        ST_APP_DETACH = 4'd1,
        ST_DFU_IDLE   = 4'd2,
        ST_DN_SYNC    = 4'd3,
        ST_DN_BUSY    = 4'd4,
        ST_DN_IDLE    = 4'd5,
        ST_MAN_SYNC   = 4'd6,
        ST_MAN        = 4'd7,
        ST_MAN_WAIT   = 4'd8,
        ST_UP_IDLE    = 4'd9,
        ST_ERROR      = 4'd10
    } dfu_phase_t;

    // Class requests
    typedef enum logic [2:0] {
        CMD_DETACH    = 3'd0,
        CMD_DOWNLOAD  = 3'd1,
        CMD_UPLOAD    = 3'd2,
        CMD_GETSTATUS = 3'd3,
        CMD_CLRSTATUS = 3'd4,
        CMD_GETSTATE  = 3'd5,
        CMD_ABORT     = 3'd6,
        CMD_MANIFEST  = 3'd7
    } dfu_cmd_t;

    // Status codes
    localparam logic [3:0] STAT_OK          = 4'd0;
    localparam logic [3:0] STAT_ERR_FILE    = 4'd2;
    localparam logic [3:0] STAT_ERR_NOTDONE = 4'd9;

    // Poll timeouts in milliseconds
    localparam logic [15:0] POLL_DEFAULT_MS = 16'd1;
    localparam logic [15:0] POLL_BUSY_MS    = 16'd100;
    localparam logic [15:0] POLL_MANIF_MS   = 16'd5000;
    localparam logic [15:0] POLL_WAIT_MS    = 16'd500;

    // Register map (word index)
    localparam int          ADDR_WIDTH        = 4;
    localparam logic [1:0]  REG_XFER_SIZE     = 2'd0;
    localparam logic [1:0]  REG_ATTRIBUTES    = 2'd1;
    localparam logic [1:0]  REG_MODE_STRING   = 2'd2;

    localparam logic [15:0] XFER_SIZE_RST     = 16'd64;
    localparam int          ATTR_WILL_DETACH  = 3;

    // Poll timeout that belongs to a state
    function automatic logic [15:0] poll_for_state(input dfu_phase_t s);
        logic [15:0] p;
        p = POLL_DEFAULT_MS;
        if (s == ST_DN_BUSY)
        begin
            p = POLL_BUSY_MS;
        end
        else if (s == ST_MAN)
        begin
            p = POLL_MANIF_MS;
        end
        else if (s == ST_MAN_WAIT)
        begin
            p = POLL_WAIT_MS;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dfu_request_state_machine_unit.sv
`default_nettype none

// DFU 1.1 request engine. Each input beat is one class request and yields
// exactly one result beat, a snapshot of status, state, poll timeout and
// download counters taken after the request is applied. A request is
// decoded against the protocol state registers in one pass of logic and
// lands in the state and result registers at the accepting edge, so a new
// request is taken in every cycle while the result side keeps up. in_stall
// rises only while a finished result is held by out_stall. Users must write
// the transfer size (0x0), attribute bits (0x4) and mode string index (0x8)
// registers over the APB port only while no request is in flight (unenforced).
module dfu_request_state_machine_unit
    import dfu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            cmd,
    input  wire logic [15:0]           length,
    input  wire logic [15:0]           detach_timeout,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [3:0]                 status_code,
    output logic [3:0]                 dfu_state_out,
    output logic [15:0]                poll_timeout,
    output logic [7:0]                 string_index,
    output logic                       ok,
    output logic [15:0]                upload_length,
    output logic [31:0]                bytes_downloaded,
    output logic [31:0]                blocks_downloaded,
    output logic [31:0]                expected_bytes,
    output logic [31:0]                write_offset,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [15:0] xfer_size_reg;
    logic [3:0]  attribute_reg;
    logic [7:0]  mode_string_reg;

    dfu_phase_t  state_reg,    state_next;
    logic [3:0]  status_reg,   status_next;
    logic [15:0] poll_reg,     poll_next;
    logic [31:0] byte_reg,     byte_next;
    logic [31:0] block_reg,    block_next;
    logic [31:0] expected_reg, expected_next;
    logic [31:0] offset_reg,   offset_next;

    logic        out_valid_reg;
    logic        ok_reg,       ok_next;
    logic [15:0] up_len_reg,   up_len_next;
    logic [7:0]  str_idx_reg,  str_idx_next;

    logic        accept;
    logic        cfg_write;
    logic [1:0]  reg_index;
    dfu_cmd_t    req;
    logic [31:0] byte_sum;
    logic        dn_state_ok;
    logic        up_state_ok;
    logic        oversize;

    // Handshake: hold the input while a result waits
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign req       = dfu_cmd_t'(cmd);

    assign dn_state_ok = (state_reg == ST_DFU_IDLE) || (state_reg == ST_DN_IDLE);
    assign up_state_ok = (state_reg == ST_DFU_IDLE) || (state_reg == ST_UP_IDLE)
                      || (state_reg == ST_ERROR);
    assign oversize    = length > xfer_size_reg;
    assign byte_sum    = byte_reg + {16'd0, length};

    // Configuration port
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xfer_size_reg   <= XFER_SIZE_RST;
            attribute_reg   <= 4'd0;
            mode_string_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_XFER_SIZE:   xfer_size_reg   <= pwdata[15:0];
                REG_ATTRIBUTES:  attribute_reg   <= pwdata[3:0];
                REG_MODE_STRING: mode_string_reg <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_index)
            REG_XFER_SIZE:   prdata = {16'd0, xfer_size_reg};
            REG_ATTRIBUTES:  prdata = {28'd0, attribute_reg};
            REG_MODE_STRING: prdata = {24'd0, mode_string_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Next protocol state
    always_comb
    begin
        state_next = state_reg;
        unique case (req) inside
            CMD_DETACH:
            begin
                if ((state_reg == ST_APP_IDLE) || (state_reg == ST_DFU_IDLE))
                begin
                    state_next = attribute_reg[ATTR_WILL_DETACH] ? ST_DFU_IDLE
                                                                 : ST_APP_DETACH;
                end
            end
            CMD_DOWNLOAD:
            begin
                if (!dn_state_ok)
                begin
                    state_next = ST_ERROR;
                end
                else if (length == 16'd0)
                begin
                    state_next = (state_reg == ST_DN_IDLE) ? ST_MAN_SYNC : ST_DN_SYNC;
                end
                else if (oversize)
                begin
                    state_next = ST_ERROR;
                end
                else
                begin
                    state_next = ST_DN_IDLE;
                end
            end
            CMD_UPLOAD:
            begin
                if (up_state_ok)
                begin
                    state_next = ST_UP_IDLE;
                end
            end
            CMD_CLRSTATUS:
            begin
                if (state_reg == ST_ERROR)
                begin
                    state_next = ST_DFU_IDLE;
                end
            end
            CMD_ABORT:
            begin
                state_next = ST_DFU_IDLE;
            end
            CMD_MANIFEST:
            begin
                if ((state_reg == ST_MAN_SYNC) || (state_reg == ST_MAN))
                begin
                    state_next = ST_MAN_WAIT;
                end
            end
            CMD_GETSTATUS, CMD_GETSTATE:
            begin
                state_next = state_reg;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // Status, timeout, counters and result fields
    always_comb
    begin
        status_next   = status_reg;
        poll_next     = poll_reg;
        byte_next     = byte_reg;
        block_next    = block_reg;
        expected_next = expected_reg;
        offset_next   = offset_reg;
        ok_next       = 1'b1;
        up_len_next   = 16'd0;
        unique case (req) inside
            CMD_DETACH:
            begin
                if ((state_reg == ST_APP_IDLE) || (state_reg == ST_DFU_IDLE))
                begin
                    poll_next = detach_timeout;
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            CMD_DOWNLOAD:
            begin
                if (!dn_state_ok)
                begin
                    status_next = STAT_ERR_NOTDONE;
                    ok_next     = 1'b0;
                end
                else if (length == 16'd0)
                begin
                    // empty block in dnload-idle starts manifestation
                    if (state_reg != ST_DN_IDLE)
                    begin
                        poll_next = poll_for_state(state_next);
                        ok_next   = (status_reg == STAT_OK);
                    end
                end
                else if (oversize)
                begin
                    status_next = STAT_ERR_FILE;
                    ok_next     = 1'b0;
                end
                else
                begin
                    byte_next   = byte_sum;
                    block_next  = block_reg + 32'd1;
                    offset_next = offset_reg + {16'd0, length};
                    status_next = STAT_OK;
                    poll_next   = poll_for_state(state_next);
                    // latch the total on the first short block
                    if ((length < xfer_size_reg) && (expected_reg == 32'd0))
                    begin
                        expected_next = byte_sum;
                    end
                end
            end
            CMD_UPLOAD:
            begin
                if (up_state_ok)
                begin
                    up_len_next = oversize ? xfer_size_reg : length;
                    status_next = STAT_OK;
                end
                else
                begin
                    status_next = STAT_ERR_NOTDONE;
                    ok_next     = 1'b0;
                end
            end
            CMD_CLRSTATUS:
            begin
                if (state_reg == ST_ERROR)
                begin
                    status_next = STAT_OK;
                end
            end
            CMD_ABORT:
            begin
                byte_next     = 32'd0;
                block_next    = 32'd0;
                expected_next = 32'd0;
                status_next   = STAT_OK;
                poll_next     = POLL_DEFAULT_MS;
            end
            CMD_MANIFEST:
            begin
                if ((state_reg == ST_MAN_SYNC) || (state_reg == ST_MAN))
                begin
                    poll_next = POLL_MANIF_MS;
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            CMD_GETSTATUS, CMD_GETSTATE:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
        str_idx_next = (state_next >= ST_DFU_IDLE) ? mode_string_reg : 8'd0;
    end

    // Advance protocol state on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_DFU_IDLE;
            status_reg   <= STAT_OK;
            poll_reg     <= POLL_DEFAULT_MS;
            byte_reg     <= 32'd0;
            block_reg    <= 32'd0;
            expected_reg <= 32'd0;
            offset_reg   <= 32'd0;
        end
        else if (accept)
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            poll_reg     <= poll_next;
            byte_reg     <= byte_next;
            block_reg    <= block_next;
            expected_reg <= expected_next;
            offset_reg   <= offset_next;
        end
    end

    // Result valid: set on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg      <= ok_next;
            up_len_reg  <= up_len_next;
            str_idx_reg <= str_idx_next;
        end
    end

    // State registers only move with a new result, so they serve as its payload
    assign out_valid         = out_valid_reg;
    assign status_code       = status_reg;
    assign dfu_state_out     = state_reg;
    assign poll_timeout      = poll_reg;
    assign string_index      = str_idx_reg;
    assign ok                = ok_reg;
    assign upload_length     = up_len_reg;
    assign bytes_downloaded  = byte_reg;
    assign blocks_downloaded = block_reg;
    assign expected_bytes    = expected_reg;
    assign write_offset      = offset_reg;

    // Checks
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with no result pending");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

    a_bad_download_errors: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req == CMD_DOWNLOAD) && !dn_state_ok)
        |=> (state_reg == ST_ERROR) && (status_reg == STAT_ERR_NOTDONE) && !ok_reg)
        else $error("download in wrong state did not enter error");

    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req == CMD_ABORT))
        |=> (state_reg == ST_DFU_IDLE) && (byte_reg == 32'd0) && (block_reg == 32'd0)
            && (offset_reg == $past(offset_reg)))
        else $error("abort did not clear totals or disturbed write offset");

endmodule

`default_nettype wire
